// File: hdl/pixel_cell_region_map_top_defines.svh
// Assertion macros used by the pixel cell region map back end (crm_back).
`ifndef PIXEL_CELL_REGION_MAP_TOP_DEFINES_SVH
`define PIXEL_CELL_REGION_MAP_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define PCRM_ASSERT_IMP(name, clk_s, rst_n_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("pixel_cell_region_map: assertion failed");

// Implication checked in the cycle after the antecedent.
`define PCRM_ASSERT_NXT(name, clk_s, rst_n_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("pixel_cell_region_map: assertion failed");

`endif

// File: hdl/crm_pkg.sv
// Types, codes and defaults shared by the cell region map modules.
package crm_pkg;

	localparam int MAX_ROWS_DEF   = 64;
	localparam int MAX_COLS_DEF   = 64;
	localparam int COORD_BITS_DEF = 12;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_SEQ    = 2'd2;
	localparam logic [1:0] CMD_GRID   = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_BIG     = 2'd2;

	localparam logic [2:0] REG_CELL_W = 3'd0;
	localparam logic [2:0] REG_CELL_H = 3'd1;
	localparam logic [2:0] REG_ROWS   = 3'd2;
	localparam logic [2:0] REG_COLS   = 3'd3;
	localparam logic [2:0] REG_MAX_W  = 3'd4;
	localparam logic [2:0] REG_MAX_H  = 3'd5;

	localparam logic [15:0] OUTSIDE_REGION = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] pixel_y;
		logic [11:0] pixel_x;
		logic [5:0]  cell_row;
		logic [5:0]  cell_col;
		logic [15:0] entry_value;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [12:0] block_width;
		logic [12:0] block_height;
	} in_word_t;

	typedef struct packed {
		logic [15:0] region;
		logic [1:0]  status;
	} out_word_t;

	typedef struct packed {
		logic [12:0] cell_width;
		logic [12:0] cell_height;
		logic [6:0]  row_count;
		logic [6:0]  col_count;
		logic [12:0] max_image_width;
		logic [12:0] max_image_height;
	} cfg_t;

	typedef struct packed {
		in_word_t word;
		logic     oversize;
	} q_item_t;

	typedef struct packed {
		logic valid;
		logic clearing;
	} back_stat_t;

	function automatic logic [12:0] nz13(input logic [12:0] v);
		return (v == 13'd0) ? 13'd1 : v;
	endfunction

endpackage

// File: hdl/crm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module crm_div
	import crm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [12:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [15:0] quotient
);

	logic [12:0] rem_q;
	logic [15:0] quo_q;
	logic [12:0] dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [13:0] trial;

	assign trial = {rem_q, quo_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 13'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial[12:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/crm_front.sv
// Front end: accepts words, flags oversize grid fills and queues them.
module crm_front
	import crm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_word_t   in_word,
	input  cfg_t       cfg,
	input  logic       clearing,
	output logic       q_valid,
	output q_item_t    q_item,
	input  logic       q_pop
);

	q_item_t    q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	q_item_t    new_item;

	assign in_stall = (count_q == 2'd2) || clearing;
	assign push     = in_valid && !in_stall;

	always_comb begin
		new_item.word     = in_word;
		new_item.oversize = (in_word.image_width > cfg.max_image_width) ||
			(in_word.image_height > cfg.max_image_height);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_item  = q_mem_q[rd_ptr_q];

endmodule

// File: hdl/crm_back.sv
// Back end: command sequencer, cell table memory and result register.
`include "pixel_cell_region_map_top_defines.svh"
module crm_back
	import crm_pkg::*;
#(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_valid,
	input  q_item_t    q_item,
	output logic       q_pop,
	output back_stat_t stat,
	output logic       out_valid,
	input  logic       out_stall,
	output out_word_t  out_word
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_LY   = 4'd2;
	localparam logic [3:0] S_LX   = 4'd3;
	localparam logic [3:0] S_LRD  = 4'd4;
	localparam logic [3:0] S_SF   = 4'd5;
	localparam logic [3:0] S_GPR  = 4'd6;
	localparam logic [3:0] S_GROW = 4'd7;
	localparam logic [3:0] S_GBY  = 4'd8;
	localparam logic [3:0] S_GCOL = 4'd9;
	localparam logic [3:0] S_GBX  = 4'd10;
	localparam logic [3:0] S_OUT  = 4'd11;

	logic [15:0] mem_q [DEPTH];
	logic [15:0] rd_data_q;

	logic [3:0]  state_q, state_d;
	in_word_t    item_q, item_d;
	logic [6:0]  r_q, r_d, c_q, c_d;
	logic [13:0] ry_q, ry_d, cx_q, cx_d;
	logic [15:0] m_q, m_d;
	logic [15:0] per_row_q, per_row_d;
	logic [15:0] by_q, by_d;
	logic [15:0] lk_row_q, lk_row_d;
	logic [ADDR_W-1:0] clr_q, clr_d;
	out_word_t   res_q, res_d;
	logic        out_valid_q;
	out_word_t   out_word_q;
	logic        out_load;

	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [15:0]       mem_wdata;

	logic        div_start, div_busy, div_done;
	logic [15:0] div_dividend, div_quot;
	logic [12:0] div_divisor;

	logic [6:0]  rows_eff, cols_eff;
	logic [12:0] cw, ch, bw, bh;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
		return ADDR_W'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	assign rows_eff = (32'(cfg.row_count) < MAX_ROWS) ? cfg.row_count : 7'(MAX_ROWS);
	assign cols_eff = (32'(cfg.col_count) < MAX_COLS) ? cfg.col_count : 7'(MAX_COLS);
	assign cw = nz13(cfg.cell_width);
	assign ch = nz13(cfg.cell_height);
	assign bw = nz13(item_q.block_width);
	assign bh = nz13(item_q.block_height);

	crm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		r_d          = r_q;
		c_d          = c_q;
		ry_d         = ry_q;
		cx_d         = cx_q;
		m_d          = m_q;
		per_row_d    = per_row_q;
		by_d         = by_q;
		lk_row_d     = lk_row_q;
		clr_d        = clr_q;
		res_d        = res_q;
		q_pop        = 1'b0;
		out_load     = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = 13'd1;
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (32'(clr_q) == DEPTH - 1) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + ADDR_W'(1);
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_item.word;
					res_d  = '{region: 16'd0, status: ST_DONE};
					unique case (q_item.word.cmd)
						CMD_LOOKUP: begin
							div_start    = 1'b1;
							div_dividend = 16'(q_item.word.pixel_y) & COORD_MASK;
							div_divisor  = ch;
							state_d      = S_LY;
						end
						CMD_WRITE: begin
							if ({1'b0, q_item.word.cell_row} >= rows_eff ||
								{1'b0, q_item.word.cell_col} >= cols_eff) begin
								res_d.status = ST_OUTSIDE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cell_addr({1'b0, q_item.word.cell_row},
									{1'b0, q_item.word.cell_col});
								mem_wdata = q_item.word.entry_value;
							end
							state_d = S_OUT;
						end
						CMD_SEQ: begin
							r_d = '0;
							c_d = '0;
							m_d = '0;
							state_d = (rows_eff == 7'd0 || cols_eff == 7'd0) ? S_OUT : S_SF;
						end
						CMD_GRID: begin
							if (q_item.oversize) begin
								res_d.status = ST_BIG;
								state_d      = S_OUT;
							end else begin
								div_start    = 1'b1;
								div_dividend = 16'(q_item.word.image_width);
								div_divisor  = nz13(q_item.word.block_width);
								state_d      = S_GPR;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LY: begin
				if (div_done) begin
					lk_row_d     = div_quot;
					div_start    = 1'b1;
					div_dividend = 16'(item_q.pixel_x) & COORD_MASK;
					div_divisor  = cw;
					state_d      = S_LX;
				end
			end
			S_LX: begin
				if (div_done) begin
					if (lk_row_q >= 16'(rows_eff) || div_quot >= 16'(cols_eff)) begin
						res_d   = '{region: OUTSIDE_REGION, status: ST_OUTSIDE};
						state_d = S_OUT;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = cell_addr(lk_row_q[6:0], div_quot[6:0]);
						state_d   = S_LRD;
					end
				end
			end
			S_LRD: begin
				res_d   = '{region: rd_data_q, status: ST_DONE};
				state_d = S_OUT;
			end
			S_SF: begin
				mem_we    = 1'b1;
				mem_waddr = cell_addr(r_q, c_q);
				mem_wdata = m_q;
				m_d       = m_q + 16'd1;
				if (c_q == cols_eff - 7'd1) begin
					c_d = '0;
					if (r_q == rows_eff - 7'd1) begin
						state_d = S_OUT;
					end else begin
						r_d = r_q + 7'd1;
					end
				end else begin
					c_d = c_q + 7'd1;
				end
			end
			S_GPR: begin
				if (div_done) begin
					per_row_d = div_quot;
					r_d       = '0;
					ry_d      = '0;
					state_d   = S_GROW;
				end
			end
			S_GROW: begin
				if (r_q < rows_eff && ry_q < {1'b0, item_q.image_height}) begin
					div_start    = 1'b1;
					div_dividend = 16'(ry_q);
					div_divisor  = bh;
					state_d      = S_GBY;
				end else begin
					state_d = S_OUT;
				end
			end
			S_GBY: begin
				if (div_done) begin
					by_d    = div_quot;
					c_d     = '0;
					cx_d    = '0;
					state_d = S_GCOL;
				end
			end
			S_GCOL: begin
				if (c_q < cols_eff && cx_q < {1'b0, item_q.image_width}) begin
					div_start    = 1'b1;
					div_dividend = 16'(cx_q);
					div_divisor  = bw;
					state_d      = S_GBX;
				end else begin
					r_d     = r_q + 7'd1;
					ry_d    = ry_q + 14'(ch);
					state_d = S_GROW;
				end
			end
			S_GBX: begin
				if (div_done) begin
					mem_we    = 1'b1;
					mem_waddr = cell_addr(r_q, c_q);
					mem_wdata = by_q * per_row_q + div_quot;
					c_d       = c_q + 7'd1;
					cx_d      = cx_q + 14'(cw);
					state_d   = S_GCOL;
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_q    <= item_d;
		r_q       <= r_d;
		c_q       <= c_d;
		ry_q      <= ry_d;
		cx_q      <= cx_d;
		m_q       <= m_d;
		per_row_q <= per_row_d;
		by_q      <= by_d;
		lk_row_q  <= lk_row_d;
		res_q     <= res_d;
		if (out_load) begin
			out_word_q <= res_q;
		end
	end

	assign stat.valid    = out_valid_q;
	assign stat.clearing = (state_q == S_CLR);
	assign out_valid     = out_valid_q;
	assign out_word      = out_word_q;

	`PCRM_ASSERT_IMP(a_no_pop_while_clearing, clk, arst_n, state_q == S_CLR, !q_pop)
	`PCRM_ASSERT_IMP(a_div_start_when_free, clk, arst_n, div_start, !div_busy)
	`PCRM_ASSERT_NXT(a_read_before_data, clk, arst_n, mem_re, state_q == S_LRD)

endmodule

// File: hdl/pixel_cell_region_map_top.sv
// Top level of the pixel cell region map: config registers, front and back ends.
//
// Input channel: in_valid / in_stall / in_word carry one command word (lookup,
// entry write, sequential fill, block-grid fill). Output channel: out_valid /
// out_stall / out_word return one word with region and status per command.
// A word moves at a rising edge with valid high and stall low.
// Config: cfg_we with cfg_index and cfg_data writes one register per cycle;
// write only while no command is in flight.
// After reset the cell table is swept to zero, one entry per cycle; in_stall
// stays high during the sweep.
// A lookup runs two divisions on the shared divider, row then column, then a
// memory read. A write updates the table as it leaves the queue. A sequential
// fill numbers the cells in use in row-major order. A block-grid fill runs
// one division per covered row and one per covered cell on the divider, after
// a first division for the blocks per row.
// A two-word queue sits between the front and back ends, and a result
// register holds a finished word while out_stall is high, so the front keeps
// taking words while the receiver stalls, until the queue is full.
module pixel_cell_region_map_top
	import crm_pkg::*;
#(
	parameter int MAX_ROWS   = MAX_ROWS_DEF,
	parameter int MAX_COLS   = MAX_COLS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	cfg_t       cfg_q;
	logic       q_valid;
	q_item_t    q_item;
	logic       q_pop;
	back_stat_t stat;

	// Hold config registers; drop writes beyond the register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_width       <= 13'd8;
			cfg_q.cell_height      <= 13'd8;
			cfg_q.row_count        <= 7'd64;
			cfg_q.col_count        <= 7'd64;
			cfg_q.max_image_width  <= 13'd512;
			cfg_q.max_image_height <= 13'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_W: cfg_q.cell_width       <= cfg_data;
				REG_CELL_H: cfg_q.cell_height      <= cfg_data;
				REG_ROWS:   cfg_q.row_count        <= cfg_data[6:0];
				REG_COLS:   cfg_q.col_count        <= cfg_data[6:0];
				REG_MAX_W:  cfg_q.max_image_width  <= cfg_data;
				REG_MAX_H:  cfg_q.max_image_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept, flag oversize grid fills, queue.
	crm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.cfg      (cfg_q),
		.clearing (stat.clearing),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Back: execute commands against the table, register the result.
	crm_back #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// File: bench/tb_pixel_cell_region_map_top.sv
// Self-checking testbench for the pixel cell region map top level.
`timescale 1ns / 1ps

module tb_pixel_cell_region_map_top;
	import crm_pkg::*;

	// Scoreboard: predicts the region/status word for each accepted command
	// word and checks returned words in order.
	class region_scoreboard;
		logic [15:0] cell_table [0:4095];
		logic [5:0]  walk_row;
		logic [5:0]  walk_col;
		logic [15:0] last_number;
		cfg_t        regs;
		out_word_t   awaited [$];
		int          errors;

		function void clear_state();
			foreach (cell_table[i]) cell_table[i] = 16'd0;
			walk_row = 6'd0;
			walk_col = 6'd0;
			last_number = 16'd0;
			regs.cell_width = 13'd8;
			regs.cell_height = 13'd8;
			regs.row_count = 7'd64;
			regs.col_count = 7'd64;
			regs.max_image_width = 13'd512;
			regs.max_image_height = 13'd512;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [12:0] data);
			case (idx)
				REG_CELL_W: regs.cell_width = data;
				REG_CELL_H: regs.cell_height = data;
				REG_ROWS:   regs.row_count = data[6:0];
				REG_COLS:   regs.col_count = data[6:0];
				REG_MAX_W:  regs.max_image_width = data;
				REG_MAX_H:  regs.max_image_height = data;
				default: ;
			endcase
		endfunction

		function int unsigned at_least_one(int unsigned v);
			return (v == 0) ? 1 : v;
		endfunction

		function void note_input(in_word_t w);
			out_word_t   e;
			int unsigned rows, cols, r, c, cw, ch, bw, bh, per_row, by, bx, v, num;
			rows = (regs.row_count < 64) ? regs.row_count : 64;
			cols = (regs.col_count < 64) ? regs.col_count : 64;
			cw = at_least_one(regs.cell_width);
			ch = at_least_one(regs.cell_height);
			e.region = 16'd0;
			e.status = ST_DONE;
			case (w.cmd)
				CMD_LOOKUP: begin
					r = w.pixel_y / ch;
					c = w.pixel_x / cw;
					if (r >= rows || c >= cols) begin
						e.region = OUTSIDE_REGION;
						e.status = ST_OUTSIDE;
					end else begin
						e.region = cell_table[r * 64 + c];
					end
				end
				CMD_WRITE: begin
					if (w.cell_row >= rows || w.cell_col >= cols)
						e.status = ST_OUTSIDE;
					else
						cell_table[w.cell_row * 64 + w.cell_col] = w.entry_value;
				end
				CMD_SEQ: begin
					num = 0;
					for (r = 0; r < rows; r++) begin
						for (c = 0; c < cols; c++) begin
							cell_table[r * 64 + c] = num[15:0];
							walk_row = r[5:0];
							walk_col = c[5:0];
							num = (num + 1) & 16'hFFFF;
						end
					end
					last_number = num[15:0];
				end
				default: begin
					bw = at_least_one(w.block_width);
					bh = at_least_one(w.block_height);
					if (w.image_width > regs.max_image_width ||
							w.image_height > regs.max_image_height) begin
						e.status = ST_BIG;
					end else begin
						per_row = w.image_width / bw;
						for (r = 0; r < rows && r * ch < w.image_height; r++) begin
							by = (r * ch) / bh;
							for (c = 0; c < cols && c * cw < w.image_width; c++) begin
								bx = (c * cw) / bw;
								v = (by * per_row + bx) & 16'hFFFF;
								cell_table[r * 64 + c] = v[15:0];
								walk_row = r[5:0];
								walk_col = c[5:0];
								last_number = v[15:0];
							end
						end
					end
				end
			endcase
			awaited = {awaited, e};
		endfunction

		function void check_result(out_word_t got);
			out_word_t e;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: region %h status %0d", got.region, got.status);
				return;
			end
			e = awaited.pop_front();
			if (got.region !== e.region || got.status !== e.status) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected region %h status %0d, got region %h status %0d",
						e.region, e.status, got.region, got.status);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_CELL_W;
	logic [12:0] cfg_data = '0;

	region_scoreboard sb;
	bit quiet_out;

	pixel_cell_region_map_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Observe both channels and the config port at each edge, before updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_input(in_word);
			if (out_valid && !out_stall)
				sb.check_result(out_word);
		end
	end

	// Receiver stalls: mostly short bursts, a few long ones, and quiet stretches.
	initial begin
		int n;
		forever begin
			if (quiet_out || $urandom_range(0, 9) < 3) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 60)) @(posedge clk);
			end else begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	// Send one word, with a random idle gap first unless no_gap is set; hold valid until accepted.
	task automatic send_word(in_word_t w, bit no_gap);
		int gap;
		gap = 0;
		if (!no_gap) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				9:          gap = $urandom_range(15, 80);
				default:    gap = $urandom_range(1, 4);
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// Drain the block, then let it settle before touching registers.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [12:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [12:0] cw, logic [12:0] ch, logic [6:0] rows,
			logic [6:0] cols, logic [12:0] mw, logic [12:0] mh);
		write_reg(REG_CELL_W, cw);
		write_reg(REG_CELL_H, ch);
		write_reg(REG_ROWS, {6'd0, rows});
		write_reg(REG_COLS, {6'd0, cols});
		write_reg(REG_MAX_W, mw);
		write_reg(REG_MAX_H, mh);
	endtask

	function automatic in_word_t noise_word();
		in_word_t     w;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		return w;
	endfunction

	function automatic in_word_t make_word(logic [1:0] cmd, int a, int b, int c, int d);
		in_word_t w;
		w = noise_word();
		w.cmd = cmd;
		case (cmd)
			CMD_LOOKUP: begin
				w.pixel_y = 12'(a);
				w.pixel_x = 12'(b);
			end
			CMD_WRITE: begin
				w.cell_row = 6'(a);
				w.cell_col = 6'(b);
				w.entry_value = 16'(c);
			end
			CMD_GRID: begin
				w.image_width = 13'(a);
				w.image_height = 13'(b);
				w.block_width = 13'(c);
				w.block_height = 13'(d);
			end
			default: ;
		endcase
		return w;
	endfunction

	// Build one random word, biased toward cells inside the table in use.
	function automatic in_word_t random_word();
		in_word_t    w;
		int unsigned rows, cols, cw, ch, span, pick;
		rows = (sb.regs.row_count < 64) ? sb.regs.row_count : 64;
		cols = (sb.regs.col_count < 64) ? sb.regs.col_count : 64;
		cw = (sb.regs.cell_width == 0) ? 1 : sb.regs.cell_width;
		ch = (sb.regs.cell_height == 0) ? 1 : sb.regs.cell_height;
		w = noise_word();
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			w.cmd = CMD_LOOKUP;
			if ($urandom_range(0, 4) != 0) begin
				span = ch * (rows + 1);
				w.pixel_y = 12'($urandom_range(0, (span > 4096) ? 4095 : span - 1));
				span = cw * (cols + 1);
				w.pixel_x = 12'($urandom_range(0, (span > 4096) ? 4095 : span - 1));
			end
		end else if (pick < 90) begin
			w.cmd = CMD_WRITE;
			if ($urandom_range(0, 3) != 0) begin
				w.cell_row = 6'($urandom_range(0, (rows == 0) ? 0 : rows - 1));
				w.cell_col = 6'($urandom_range(0, (cols == 0) ? 0 : cols - 1));
			end
		end else if (pick < 93) begin
			w.cmd = CMD_SEQ;
		end else begin
			// Keep covered cells few: the grid walk is slow per cell.
			w.cmd = CMD_GRID;
			span = cw * 6;
			w.image_width = 13'($urandom_range(0, (span > 4096) ? 4096 : span));
			span = ch * 4;
			w.image_height = 13'($urandom_range(0, (span > 4096) ? 4096 : span));
			if ($urandom_range(0, 4) == 0)
				w.image_width = 13'($urandom_range(0, 8191));
			if ($urandom_range(0, 2) != 0) begin
				w.block_width = 13'($urandom_range(0, 64));
				w.block_height = 13'($urandom_range(0, 64));
			end
		end
		return w;
	endfunction

	initial begin
		int        phase;
		int unsigned k;
		logic [12:0] sizes [0:5];
		sb = new();
		sb.clear_state();
		quiet_out = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset config, table corners, fills, and the edge cases.
		send_word(make_word(CMD_LOOKUP, 0, 0, 0, 0), 1);
		send_word(make_word(CMD_LOOKUP, 4095, 4095, 0, 0), 0);
		send_word(make_word(CMD_WRITE, 0, 0, 16'hFFFF, 0), 0);
		send_word(make_word(CMD_WRITE, 63, 63, 16'hA5A5, 0), 1);
		send_word(make_word(CMD_LOOKUP, 504, 511, 0, 0), 1);
		send_word(make_word(CMD_LOOKUP, 7, 7, 0, 0), 0);
		send_word(make_word(CMD_LOOKUP, 512, 0, 0, 0), 0);
		send_word(make_word(CMD_SEQ, 0, 0, 0, 0), 0);
		send_word(make_word(CMD_LOOKUP, 511, 511, 0, 0), 0);
		send_word(make_word(CMD_GRID, 512, 512, 16, 16), 0);
		send_word(make_word(CMD_LOOKUP, 300, 200, 0, 0), 0);
		send_word(make_word(CMD_GRID, 513, 8, 1, 1), 0);
		send_word(make_word(CMD_GRID, 8, 8191, 1, 1), 0);
		send_word(make_word(CMD_GRID, 0, 40, 1, 1), 0);
		send_word(make_word(CMD_GRID, 40, 24, 0, 0), 0);
		send_word(make_word(CMD_LOOKUP, 16, 32, 0, 0), 0);
		wait_drained();

		// Small table with zero cell sizes: cells act as one pixel wide.
		write_all(13'd0, 13'd0, 7'd3, 7'd5, 13'd4096, 13'd4096);
		send_word(make_word(CMD_WRITE, 10, 10, 16'h1234, 0), 0);
		send_word(make_word(CMD_WRITE, 2, 4, 16'h0F0F, 0), 0);
		send_word(make_word(CMD_LOOKUP, 2, 4, 0, 0), 0);
		send_word(make_word(CMD_LOOKUP, 3, 0, 0, 0), 0);
		send_word(make_word(CMD_GRID, 4096, 4096, 8191, 2), 0);
		send_word(make_word(CMD_SEQ, 0, 0, 0, 0), 0);
		send_word(make_word(CMD_LOOKUP, 1, 1, 0, 0), 0);
		wait_drained();

		// Random phases, each with its own register setting.
		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: write_all(13'd8, 13'd8, 7'd64, 7'd64, 13'd512, 13'd512);
				1: write_all(13'd1, 13'd1, 7'd64, 7'd64, 13'd4096, 13'd4096);
				2: write_all(13'd4096, 13'd4096, 7'd1, 7'd1, 13'd1, 13'd1);
				3: write_all(13'd3, 13'd5, 7'd127, 7'd127, 13'd8191, 13'd8191);
				4: write_all(13'd64, 13'd64, 7'd64, 7'd64, 13'd4096, 13'd4096);
				default: begin
					foreach (sizes[i]) sizes[i] = 13'($urandom_range(1, 4096));
					sizes[0] = ($urandom_range(0, 1) != 0) ?
						13'($urandom_range(1, 32)) : sizes[0];
					sizes[1] = ($urandom_range(0, 1) != 0) ?
						13'($urandom_range(1, 32)) : sizes[1];
					write_all(sizes[0], sizes[1], 7'($urandom_range(1, 127)),
						7'($urandom_range(1, 127)), sizes[4], sizes[5]);
				end
			endcase
			quiet_out = (phase == 4);
			for (k = 0; k < 200; k++)
				send_word(random_word(), (phase == 4) || (k % 50 < 10));
			wait_drained();
		end
		quiet_out = 1'b0;

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb_pixel_cell_region_map_top: clean");
		else
			$display("tb_pixel_cell_region_map_top: errors");
		$finish;
	end

	initial begin
		#50ms;
		$display("tb_pixel_cell_region_map_top: errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/crm_pkg.sv
hdl/crm_div.sv
hdl/crm_front.sv
hdl/crm_back.sv
hdl/pixel_cell_region_map_top.sv
bench/tb_pixel_cell_region_map_top.sv
